@@ hdl/lrii_pkg.sv @@
package lrii_pkg;

  localparam int W        = 32;
  localparam int F        = 16;
  localparam int TolBits  = 16;
  localparam int SqBits   = W + 2;
  localparam int DescBits = 2 * SqBits;
  localparam int NumBits  = W + 4;
  localparam int DenBits  = W + 1;
  localparam int CfgIdxBits = 1;

  localparam logic [CfgIdxBits-1:0] CfgCleanMode = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgTolerance = 1'b1;

  localparam logic ModeLinear = 1'b0;
  localparam logic ModeQuad   = 1'b1;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    logic  mode;
    word_t coef_c0;
    word_t coef_c1;
    word_t coef_c2;
    word_t lower_bound;
    word_t upper_bound;
  } in_item_t;

  typedef struct packed {
    word_t root_value;
    logic  last_of_run;
  } out_item_t;

  typedef struct packed {
    logic                quad;
    word_t               c0;
    word_t               c1;
    word_t               c2;
    word_t               lb;
    word_t               ub;
    logic [DescBits-1:0] desc;
  } job_t;

  function automatic logic [W-1:0] mag_w(word_t v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

@@ hdl/lrii_front.sv @@
module lrii_front import lrii_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     clean_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic             s1_valid_q;
  in_item_t         item_q;
  logic [2*W-1:0]   p_q;
  logic [2*W-1:0]   pq_q;

  logic             accept, advance, drop, opp;
  logic [2*W+1:0]   q4, p_ext;
  logic [2*W+2:0]   sum, diff;

  always_comb begin
    q4    = {pq_q, 2'b00};
    p_ext = {2'b00, p_q};
    sum   = {1'b0, p_ext} + {1'b0, q4};
    diff  = {1'b0, p_ext} - {1'b0, q4};
    // Opposite signs (or a zero constant term) make 4*c0*c2 add to c1*c1.
    opp   = (item_q.coef_c0[W-1] != item_q.coef_c2[W-1]) || (item_q.coef_c0 == '0);
    if (item_q.mode == ModeQuad) begin
      drop = (item_q.coef_c2 == '0) || (opp ? (sum == '0) : (p_ext <= q4));
    end else begin
      drop = (item_q.coef_c1 == '0) || (clean_i && !item_q.coef_c1[W-1]);
    end
    job_o.quad = (item_q.mode == ModeQuad);
    job_o.c0   = item_q.coef_c0;
    job_o.c1   = item_q.coef_c1;
    job_o.c2   = item_q.coef_c2;
    job_o.lb   = item_q.lower_bound;
    job_o.ub   = item_q.upper_bound;
    job_o.desc = {1'b0, (opp ? sum : diff)};
  end

  assign advance    = s1_valid_q && (drop || !full_i);
  assign push_o     = s1_valid_q && !drop && !full_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      p_q    <= mag_w(in_item_i.coef_c1) * mag_w(in_item_i.coef_c1);
      pq_q   <= mag_w(in_item_i.coef_c0) * mag_w(in_item_i.coef_c2);
    end
  end

endmodule

@@ hdl/lrii_fifo.sv @@
module lrii_fifo import lrii_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ hdl/lrii_div.sv @@
module lrii_div import lrii_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic signed [DenBits-1:0] den_i,
  output logic                      done_o,
  output word_t                     quo_o
);

  localparam int DivW    = NumBits + F;
  localparam int RemBits = DenBits + 1;
  localparam int CntW    = $clog2(W);
  localparam logic [W-1:0] PosLim = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NegLim = {1'b1, {(W-1){1'b0}}};

  logic               busy_q, done_q, neg_q, sat_q;
  logic [CntW-1:0]    cnt_q;
  logic [RemBits-1:0] rem_q;
  logic [DenBits-1:0] dm_q;
  logic [W-1:0]       lo_q, q_q;

  logic [NumBits-1:0] nm;
  logic [DenBits-1:0] dm;
  logic [DivW-1:0]    big, hi;
  logic [RemBits-1:0] trial;
  logic               ge;
  logic [W-1:0]       lim, qf;

  always_comb begin
    nm    = num_i[NumBits-1] ? (~num_i + 1'b1) : num_i;
    dm    = den_i[DenBits-1] ? (~den_i + 1'b1) : den_i;
    big   = {nm, {F{1'b0}}};
    hi    = big >> W;
    trial = {rem_q[RemBits-2:0], lo_q[W-1]};
    ge    = trial >= {1'b0, dm_q};
    lim   = neg_q ? NegLim : PosLim;
    qf    = (sat_q || (q_q > lim)) ? lim : q_q;
    quo_o = neg_q ? (~qf + 1'b1) : qf;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NumBits-1] != den_i[DenBits-1];
      // A quotient of 2^W or more is caught here and saturates.
      sat_q <= hi >= DivW'(dm);
      rem_q <= RemBits'(hi);
      lo_q  <= big[W-1:0];
      dm_q  <= dm;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, dm_q}) : trial;
      lo_q  <= {lo_q[W-2:0], 1'b0};
      q_q   <= {q_q[W-2:0], ge};
    end
  end

endmodule

@@ hdl/lrii_back.sv @@
module lrii_back import lrii_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clean_i,
  input  logic [TolBits-1:0] tol_i,
  input  logic               empty_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o
);

  typedef enum logic [2:0] {BkIdle, BkSqrt, BkStart, BkDiv, BkEmit} bk_state_e;

  localparam int CntW = $clog2(SqBits);

  bk_state_e           state_q;
  job_t                job_q;
  logic [CntW-1:0]     cnt_q;
  logic [DescBits-1:0] x_q;
  logic [SqBits+1:0]   rem_q;
  logic [SqBits-1:0]   root_q;
  word_t               res0_q, res1_q;
  logic [1:0]          nres_q;
  logic                idx_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [SqBits+1:0]          rem_sh, trial;
  logic                       ge;
  logic signed [NumBits-1:0]  s_ext, c1e, c0e, num_a, num_b;
  logic signed [DenBits-1:0]  den_a, den_b;
  logic                       done_a, done_b, start, load;
  word_t                      qa, qb, ur, lr;
  logic signed [W:0]          lo_edge, lb_e, ub_e, ur_e, lr_e;
  logic                       win_l, win_u;
  logic [1:0]                 n;
  word_t                      r0, r1;

  always_comb begin
    rem_sh = {rem_q[SqBits-1:0], x_q[DescBits-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;

    s_ext = {2'b00, root_q};
    c1e   = {{(NumBits-W){job_q.c1[W-1]}}, job_q.c1};
    c0e   = {{(NumBits-W){job_q.c0[W-1]}}, job_q.c0};
    num_a = job_q.quad ? (s_ext - c1e) : -c0e;
    num_b = -c1e - s_ext;
    den_b = {job_q.c2, 1'b0};
    den_a = job_q.quad ? den_b : {job_q.c1[W-1], job_q.c1};

    // A negative leading coefficient flips which quotient is the upper root.
    ur = job_q.c2[W-1] ? qb : qa;
    lr = job_q.c2[W-1] ? qa : qb;
    lb_e    = {job_q.lb[W-1], job_q.lb};
    ub_e    = {job_q.ub[W-1], job_q.ub};
    ur_e    = {ur[W-1], ur};
    lr_e    = {lr[W-1], lr};
    lo_edge = lb_e - (clean_i ? {{(W+1-TolBits){1'b0}}, tol_i} : '0);
    win_l   = (lr_e > lo_edge) && (lr_e < ub_e);
    win_u   = (ur_e > lo_edge) && (ur_e < ub_e);

    n  = 2'd0;
    r0 = ur;
    r1 = lr;
    if (job_q.quad) begin
      if (win_l) begin
        // The upper root goes out untested whenever the lower one is inside.
        n = (!clean_i || !job_q.c2[W-1]) ? 2'd2 : 2'd1;
      end else if (win_u && (!clean_i || job_q.c2[W-1])) begin
        n = 2'd1;
      end
    end else begin
      r0 = qa;
      if ((clean_i || (qa > job_q.lb)) && (qa < job_q.ub)) n = 2'd1;
    end
  end

  assign pop_o       = (state_q == BkIdle) && !empty_i;
  assign start       = (state_q == BkStart);
  assign load        = (state_q == BkEmit) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  lrii_div u_div_a (
    .clk_i, .rst_ni, .start_i(start), .num_i(num_a), .den_i(den_a),
    .done_o(done_a), .quo_o(qa)
  );

  lrii_div u_div_b (
    .clk_i, .rst_ni, .start_i(start), .num_i(num_b), .den_i(den_b),
    .done_o(done_b), .quo_o(qb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= 1'b0;
      nres_q      <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BkIdle: begin
          if (!empty_i) begin
            job_q  <= job_i;
            x_q    <= job_i.desc;
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= CntW'(SqBits - 1);
            state_q <= job_i.quad ? BkSqrt : BkStart;
          end
        end
        BkSqrt: begin
          rem_q  <= ge ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[SqBits-2:0], ge};
          x_q    <= {x_q[DescBits-3:0], 2'b00};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= BkStart;
        end
        BkStart: begin
          state_q <= BkDiv;
        end
        BkDiv: begin
          if (done_a && done_b) begin
            res0_q <= r0;
            res1_q <= r1;
            nres_q <= n;
            idx_q  <= 1'b0;
            state_q <= (n == 2'd0) ? BkIdle : BkEmit;
          end
        end
        BkEmit: begin
          if (load) begin
            out_q.root_value  <= idx_q ? res1_q : res0_q;
            out_q.last_of_run <= ({1'b0, idx_q} == nres_q - 2'd1);
            idx_q             <= 1'b1;
            if ({1'b0, idx_q} == nres_q - 2'd1) state_q <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

@@ hdl/low_degree_root_in_interval.sv @@
// An accepted item is classified in the front end and queued, then passes the bit-serial square
// root (quadratic only), the two parallel dividers including their start state, and the output
// register. The back end works on one item at a time, its pace set by the square root and
// dividers; the front end takes new items while the two-entry queue has room, and items dropped
// at classification never reach the queue.
// Reset (rst_ni low, asynchronous) empties both parts and the queue, clean_mode to 0, tolerance to 3.
module low_degree_root_in_interval import lrii_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [TolBits-1:0]    cfg_data_i
);

  logic               clean_q;
  logic [TolBits-1:0] tol_q;
  logic               push, pop, full, empty;
  job_t               job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_q <= 1'b0;
      tol_q   <= TolBits'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCleanMode: clean_q <= cfg_data_i[0];
        CfgTolerance: tol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrii_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .clean_i(clean_q), .full_i(full), .push_o(push), .job_o(job_in)
  );

  lrii_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .pop_i(pop),
    .data_o(job_out), .full_o(full), .empty_o(empty)
  );

  lrii_back u_back (
    .clk_i, .rst_ni, .clean_i(clean_q), .tol_i(tol_q), .empty_i(empty),
    .job_i(job_out), .pop_o(pop), .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule

@@ hdl/lrii_checker.sv @@
module lrii_checker import lrii_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_item_t              in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_item_t             out_item_o
);

  // A stalled result beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // A stalled input beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input beat changed");

  // The second root of an item follows the first one without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_of_run |=> out_valid_o)
    else $error("second root missing after first");

  // Leaving reset, nothing is pending on either side.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("state not cleared by reset");

endmodule

bind low_degree_root_in_interval lrii_checker u_lrii_checker (.*);
